// File: design/owsfp_pkg.sv
package owsfp_pkg;

  localparam int ROBOTS_DEF = 16;

  localparam int IDX_W     = 4;
  localparam int POS_W     = 20;
  localparam int HEAD_W    = 16;
  localparam int SPD_W     = 16;
  localparam int ANG_W     = 16;
  localparam int RAD_W     = 8;
  localparam int BIAS_W    = 11;
  localparam int QSTEP_W   = 10;
  localparam int DPOS_W    = POS_W + 1;
  localparam int SIN_W     = 18;
  localparam int PROD_W    = DPOS_W + SIN_W;
  localparam int ROT1_W    = 25;
  localparam int ROT_W     = 42;
  localparam int VAL_W     = 50;
  localparam int FRAC_BITS = 24;
  localparam int LIN_SH_HI = 11;
  localparam int LIN_SH_LO = 7;

  localparam int DIV_W      = 16;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = DIV_W / DIV_STEP;

  localparam logic [16:0]        SIN_A    = 17'd102944;
  localparam logic [15:0]        SIN_B    = 16'd42047;
  localparam logic [12:0]        SIN_C    = 13'd4640;
  localparam logic signed [17:0] ROT_GAIN = 18'sd96510;
  localparam logic [ANG_W-1:0]   QUARTER  = 16'd16384;

  localparam logic [ANG_W-1:0]          ANGLE_FL_RST = 16'd10923;
  localparam logic [ANG_W-1:0]          ANGLE_BL_RST = 16'd24576;
  localparam logic [ANG_W-1:0]          ANGLE_BR_RST = 16'd40960;
  localparam logic [ANG_W-1:0]          ANGLE_FR_RST = 16'd54613;
  localparam logic [RAD_W-1:0]          RADIUS_RST   = 8'd90;
  localparam logic signed [BIAS_W-1:0]  BIAS_RST     = 11'sd0;
  localparam logic [QSTEP_W-1:0]        QSTEP_RST    = 10'd0;

  typedef enum logic [2:0] {
    REG_ENABLE,
    REG_ANGLE_FL,
    REG_ANGLE_BL,
    REG_ANGLE_BR,
    REG_ANGLE_FR,
    REG_RADIUS,
    REG_BIAS,
    REG_QSTEP
  } reg_idx_e;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [HEAD_W-1:0]       h;
  } pose_t;

  typedef struct packed {
    logic                     v;
    logic                     emit;
    logic [IDX_W-1:0]         idx;
    logic signed [DPOS_W-1:0] dx;
    logic signed [DPOS_W-1:0] dy;
    logic signed [HEAD_W-1:0] dth;
  } meta_t;

  typedef struct packed {
    logic [IDX_W-1:0]          idx;
    logic [3:0][SPD_W-1:0]     spd;
  } res_t;

endpackage

// File: design/owsfp_ram.sv
module owsfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/owsfp_sine.sv
module owsfp_sine (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [owsfp_pkg::ANG_W-1:0]      ang_i,
  output logic signed [owsfp_pkg::SIN_W-1:0] sin_o
);
  import owsfp_pkg::*;

  logic [ANG_W-1:0] ang_q;
  logic [15:0]      x_c, x_q, x3_q, x4_q, x2_q, x2b_q, t2_q, u_c;
  logic [12:0]      t1_q;
  logic [2:0]       ng_q;
  logic [31:0]      sq_c, m2_c;
  logic [27:0]      m1_c;
  logic [32:0]      m3_c;
  logic [16:0]      w_c, mag_c;
  logic signed [SIN_W-1:0] s_q;

  assign x_c  = ang_q[14] ? (16'd32768 - {1'b0, ang_q[13:0], 1'b0})
                          : {1'b0, ang_q[13:0], 1'b0};
  assign sq_c = 32'(x_c) * 32'(x_c);
  assign m1_c = 28'(SIN_C) * 28'(x2_q);
  assign u_c  = SIN_B - 16'(t1_q);
  assign m2_c = 32'(u_c) * 32'(x2b_q);
  assign w_c  = SIN_A - 17'(t2_q);
  assign m3_c = 33'(x4_q) * 33'(w_c);
  assign mag_c = m3_c[32:16];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= ang_i;
      x_q   <= x_c;
      x2_q  <= sq_c[30:15];
      ng_q[0] <= ang_q[15];
      t1_q  <= m1_c[27:15];
      x3_q  <= x_q;
      x2b_q <= x2_q;
      ng_q[1] <= ng_q[0];
      t2_q  <= m2_c[30:15];
      x4_q  <= x3_q;
      ng_q[2] <= ng_q[1];
      s_q   <= ng_q[2] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
    end
  end

  assign sin_o = s_q;

endmodule

// File: design/owsfp_quant.sv
module owsfp_quant (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [owsfp_pkg::VAL_W-1:0] val_i,
  input  logic [owsfp_pkg::QSTEP_W-1:0]      qe_i,
  output logic signed [owsfp_pkg::SPD_W-1:0] spd_o
);
  import owsfp_pkg::*;

  typedef struct packed {
    logic [QSTEP_W-1:0] rem;
    logic [DIV_W-1:0]   num;
    logic [DIV_W-1:0]   quo;
  } div_t;

  function automatic div_t div_steps(div_t s, logic [QSTEP_W-1:0] d);
    div_t           r;
    logic [QSTEP_W:0] t;
    r = s;
    for (int i = 0; i < DIV_STEP; i++) begin
      t     = {r.rem, r.num[DIV_W-1]};
      r.num = r.num << 1;
      if (t >= {1'b0, d}) begin
        t     = t - {1'b0, d};
        r.quo = {r.quo[DIV_W-2:0], 1'b1};
      end else begin
        r.quo = {r.quo[DIV_W-2:0], 1'b0};
      end
      r.rem = t[QSTEP_W-1:0];
    end
    return r;
  endfunction

  logic [VAL_W-2:0]           mag_q;
  logic                       neg_q;
  logic [VAL_W:0]             sum_c, nn_c;
  logic [DIV_W-1:0]           n_c;
  div_t                       d_q   [DIV_STAGES+1];
  logic [DIV_STAGES:0]        dn_q;
  logic [DIV_W+QSTEP_W-1:0]   prod_c;
  logic signed [SPD_W-1:0]    spd_q, sat_c;

  assign sum_c = (VAL_W+1)'(mag_q) + ((VAL_W+1)'(qe_i) << (FRAC_BITS - 1));
  assign nn_c  = sum_c >> FRAC_BITS;
  assign n_c   = (|nn_c[VAL_W:DIV_W]) ? '1 : nn_c[DIV_W-1:0];

  assign prod_c = (DIV_W+QSTEP_W)'(d_q[DIV_STAGES].quo) * (DIV_W+QSTEP_W)'(qe_i);

  always_comb begin
    if (!dn_q[DIV_STAGES]) begin
      sat_c = (prod_c > (DIV_W+QSTEP_W)'(32767)) ? 16'sh7FFF : $signed(prod_c[SPD_W-1:0]);
    end else begin
      sat_c = (prod_c > (DIV_W+QSTEP_W)'(32768)) ? 16'sh8000 : -$signed(prod_c[SPD_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q   <= val_i[VAL_W-1];
      mag_q   <= val_i[VAL_W-1] ? (VAL_W-1)'(-val_i) : val_i[VAL_W-2:0];
      d_q[0]  <= '{rem: '0, num: n_c, quo: '0};
      dn_q[0] <= neg_q;
      for (int s = 1; s <= DIV_STAGES; s++) begin
        d_q[s]  <= div_steps(d_q[s-1], qe_i);
        dn_q[s] <= dn_q[s-1];
      end
      spd_q <= sat_c;
    end
  end

  assign spd_o = spd_q;

endmodule

// File: design/owsfp_outq.sv
module owsfp_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  owsfp_pkg::res_t   data_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output owsfp_pkg::res_t   data_o
);
  import owsfp_pkg::*;

  res_t       ent_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign cnt_d   = cnt_q + 2'(push_i) - 2'(pop_i);
  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = ent_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= data_i;
    end
  end

endmodule

// File: design/omni_wheel_speed_from_pose.sv
// Omni wheel speeds from successive robot poses.
// Input channel (in_valid_i / in_ready_o): one pose word per robot index.
// Output channel (out_valid_o / out_ready_i): four wheel speeds in mm/s.
// A first pose, a reseed word, a disabled block or an unknown index gives
// no output word; a disabled block or an unknown index leaves the pose store
// untouched.
// Throughput: one word per cycle while in_ready_o is high; the pipeline
// has no loop, the pose store is read at accept and written from the first
// stage, with a bypass for back-to-back words of the same robot.
// Reset: registers take their reset values, every robot is marked as
// having no pose, the pipeline and output buffer are emptied.
// Stall: a two-word output buffer holds finished words; only when it is
// full and out_ready_i is low does the whole pipeline hold and in_ready_o
// drop. Nothing is lost or repeated. Configuration registers are written over
// the APB port by the user only while idle; the block does not enforce this.
module omni_wheel_speed_from_pose #(
  parameter int ROBOTS = owsfp_pkg::ROBOTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [4:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [owsfp_pkg::IDX_W-1:0]         robot_index_i,
  input  logic signed [owsfp_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [owsfp_pkg::POS_W-1:0]  pos_y_i,
  input  logic [owsfp_pkg::HEAD_W-1:0]        heading_i,
  input  logic                                reseed_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [owsfp_pkg::IDX_W-1:0]         out_index_o,
  output logic signed [owsfp_pkg::SPD_W-1:0]  speed_front_left_o,
  output logic signed [owsfp_pkg::SPD_W-1:0]  speed_back_left_o,
  output logic signed [owsfp_pkg::SPD_W-1:0]  speed_back_right_o,
  output logic signed [owsfp_pkg::SPD_W-1:0]  speed_front_right_o
);
  import owsfp_pkg::*;

  localparam int AW     = (ROBOTS > 1) ? $clog2(ROBOTS) : 1;
  localparam int META_D = 15;

  logic                        enable_q;
  logic [ANG_W-1:0]            angle_q [4];
  logic [RAD_W-1:0]            radius_q;
  logic signed [BIAS_W-1:0]    bias_q;
  logic [QSTEP_W-1:0]          qstep_q, qe;
  logic                        wr_en;

  logic                        en, accept, q_full, push;
  logic [AW-1:0]               in_addr, s1_addr;
  logic                        s1_v_q, s1_rs_q, s1_fwd_q;
  logic [IDX_W-1:0]            s1_idx_q;
  pose_t                       s1_pose_q, s1_fpose_q, in_pose, last, ram_rdata;
  logic                        s1_inrange, s1_wr, s1_emit;
  logic [ROBOTS-1:0]           pv_q;
  meta_t                       meta_c;
  meta_t                       meta_q [1:META_D];

  logic signed [ROT1_W-1:0]    r1_q;
  logic signed [ROT_W-1:0]     rot3_q, rot4_q, rot5_q, rot6_q;
  logic signed [VAL_W-1:0]     rb7_q;

  logic signed [SIN_W-1:0]     sin_w [4];
  logic signed [SIN_W-1:0]     cos_w [4];
  logic [ANG_W-1:0]            phi_c [4];
  logic [ANG_W-1:0]            cphi_c [4];
  logic signed [PROD_W-1:0]    p1_q [4];
  logic signed [PROD_W-1:0]    p2_q [4];
  logic signed [PROD_W:0]      dd_q [4];
  logic signed [VAL_W-1:0]     v_q [4];
  logic signed [SPD_W-1:0]     spd_w [4];
  res_t                        res_in, res_out;

  // configuration port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign qe     = (qstep_q == '0) ? QSTEP_W'(1) : qstep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b1;
      angle_q[0] <= ANGLE_FL_RST;
      angle_q[1] <= ANGLE_BL_RST;
      angle_q[2] <= ANGLE_BR_RST;
      angle_q[3] <= ANGLE_FR_RST;
      radius_q   <= RADIUS_RST;
      bias_q     <= BIAS_RST;
      qstep_q    <= QSTEP_RST;
    end else if (wr_en) begin
      unique case (reg_idx_e'(paddr[4:2]))
        REG_ENABLE:   enable_q   <= pwdata[0];
        REG_ANGLE_FL: angle_q[0] <= pwdata[ANG_W-1:0];
        REG_ANGLE_BL: angle_q[1] <= pwdata[ANG_W-1:0];
        REG_ANGLE_BR: angle_q[2] <= pwdata[ANG_W-1:0];
        REG_ANGLE_FR: angle_q[3] <= pwdata[ANG_W-1:0];
        REG_RADIUS:   radius_q   <= pwdata[RAD_W-1:0];
        REG_BIAS:     bias_q     <= $signed(pwdata[BIAS_W-1:0]);
        REG_QSTEP:    qstep_q    <= pwdata[QSTEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[4:2]))
      REG_ENABLE:   prdata = 32'(enable_q);
      REG_ANGLE_FL: prdata = 32'(angle_q[0]);
      REG_ANGLE_BL: prdata = 32'(angle_q[1]);
      REG_ANGLE_BR: prdata = 32'(angle_q[2]);
      REG_ANGLE_FR: prdata = 32'(angle_q[3]);
      REG_RADIUS:   prdata = 32'(radius_q);
      REG_BIAS:     prdata = 32'(bias_q);
      REG_QSTEP:    prdata = 32'(qstep_q);
      default:      prdata = '0;
    endcase
  end

  // input stage and pose store
  assign en         = !q_full || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;
  assign in_addr    = AW'(robot_index_i);
  assign s1_addr    = AW'(s1_idx_q);
  assign in_pose    = '{x: pos_x_i, y: pos_y_i, h: heading_i};

  owsfp_ram #(.WIDTH($bits(pose_t)), .DEPTH(ROBOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (en && s1_wr),
    .waddr_i (s1_addr),
    .wdata_i (s1_pose_q),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  assign s1_inrange = (int'(s1_idx_q) < ROBOTS);
  assign s1_wr      = s1_v_q && enable_q && s1_inrange;
  assign s1_emit    = s1_wr && !s1_rs_q && pv_q[s1_addr];
  assign last       = s1_fwd_q ? s1_fpose_q : ram_rdata;

  always_comb begin
    meta_c.v    = s1_v_q;
    meta_c.emit = s1_emit;
    meta_c.idx  = s1_idx_q;
    meta_c.dx   = DPOS_W'(s1_pose_q.x) - DPOS_W'(last.x);
    meta_c.dy   = DPOS_W'(s1_pose_q.y) - DPOS_W'(last.y);
    meta_c.dth  = $signed(s1_pose_q.h - last.h);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      pv_q   <= '0;
      for (int k = 1; k <= META_D; k++) meta_q[k] <= '0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      if (s1_wr) pv_q[s1_addr] <= 1'b1;
      meta_q[1] <= meta_c;
      for (int k = 2; k <= META_D; k++) meta_q[k] <= meta_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_idx_q   <= robot_index_i;
      s1_pose_q  <= in_pose;
      s1_rs_q    <= reseed_i;
      s1_fwd_q   <= s1_wr && (s1_addr == in_addr);
      s1_fpose_q <= s1_pose_q;
      r1_q   <= ROT1_W'($signed({1'b0, radius_q})) * ROT1_W'(meta_q[1].dth);
      rot3_q <= ROT_W'(r1_q) * ROT_W'(ROT_GAIN);
      rot4_q <= rot3_q;
      rot5_q <= rot4_q;
      rot6_q <= rot5_q;
      rb7_q  <= (VAL_W'(bias_q) <<< FRAC_BITS) - VAL_W'(rot6_q);
    end
  end

  // wheel lanes
  for (genvar g = 0; g < 4; g++) begin : g_lane
    assign phi_c[g]  = angle_q[g] + s1_pose_q.h;
    assign cphi_c[g] = phi_c[g] + QUARTER;

    owsfp_sine u_sin (.clk_i(clk_i), .en_i(en), .ang_i(phi_c[g]),  .sin_o(sin_w[g]));
    owsfp_sine u_cos (.clk_i(clk_i), .en_i(en), .ang_i(cphi_c[g]), .sin_o(cos_w[g]));

    always_ff @(posedge clk_i) begin
      if (en) begin
        p1_q[g] <= PROD_W'(meta_q[5].dx) * PROD_W'(sin_w[g]);
        p2_q[g] <= PROD_W'(meta_q[5].dy) * PROD_W'(cos_w[g]);
        dd_q[g] <= (PROD_W+1)'(p1_q[g]) - (PROD_W+1)'(p2_q[g]);
        v_q[g]  <= (VAL_W'(dd_q[g]) <<< LIN_SH_HI) - (VAL_W'(dd_q[g]) <<< LIN_SH_LO)
                   + rb7_q;
      end
    end

    owsfp_quant u_quant (
      .clk_i (clk_i),
      .en_i  (en),
      .val_i (v_q[g]),
      .qe_i  (qe),
      .spd_o (spd_w[g])
    );

    assign res_in.spd[g] = spd_w[g];
  end

  // output buffer
  assign res_in.idx = meta_q[META_D].idx;
  assign push       = en && meta_q[META_D].v && meta_q[META_D].emit;

  owsfp_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res_in),
    .pop_i   (out_valid_o && out_ready_i),
    .full_o  (q_full),
    .valid_o (out_valid_o),
    .data_o  (res_out)
  );

  assign out_index_o         = res_out.idx;
  assign speed_front_left_o  = $signed(res_out.spd[0]);
  assign speed_back_left_o   = $signed(res_out.spd[1]);
  assign speed_back_right_o  = $signed(res_out.spd[2]);
  assign speed_front_right_o = $signed(res_out.spd[3]);

  a_pose_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s1_wr) |=> pv_q[$past(s1_addr)])
    else $error("stored pose not marked valid");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(meta_q[META_D]) && $stable(s1_v_q)))
    else $error("pipeline moved during stall");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && en) |=> s1_v_q)
    else $error("accepted word missing from first stage");

endmodule

// File: sim/omni_wheel_speed_from_pose_tb.sv
`timescale 1ns / 100ps

module omni_wheel_speed_from_pose_tb;
  import owsfp_pkg::*;

  localparam int LIMIT = 400000;

  class wheel_scoreboard;
    localparam longint MOVE_GAIN = 1920;
    localparam longint TURN_GAIN = 96510;
    localparam longint QA = 102944;
    localparam longint QB = 42047;
    localparam longint QC = 4640;

    bit                       enable = 1'b1;
    logic [ANG_W-1:0]         mount[4] = '{16'd10923, 16'd24576, 16'd40960, 16'd54613};
    logic [RAD_W-1:0]         radius = 8'd90;
    logic signed [BIAS_W-1:0] bias = '0;
    logic [QSTEP_W-1:0]       qstep = '0;

    logic signed [POS_W-1:0]  last_x[16];
    logic signed [POS_W-1:0]  last_y[16];
    logic [HEAD_W-1:0]        last_h[16];
    bit                       known[16];
    res_t                     speeds_due[$];
    int                       failures = 0;

    function void set_reg(reg_idx_e r, logic [31:0] v);
      case (r)
        REG_ENABLE:   enable = v[0];
        REG_ANGLE_FL: mount[0] = v[15:0];
        REG_ANGLE_BL: mount[1] = v[15:0];
        REG_ANGLE_BR: mount[2] = v[15:0];
        REG_ANGLE_FR: mount[3] = v[15:0];
        REG_RADIUS:   radius = v[7:0];
        REG_BIAS:     bias = v[10:0];
        REG_QSTEP:    qstep = v[9:0];
        default: ;
      endcase
    endfunction

    function longint sine_q15(logic [15:0] a);
      longint x, x2, t, s;
      x = {a[13:0], 1'b0};
      if (a[14]) x = 32768 - x;
      x2 = (x * x) >>> 15;
      t = (QC * x2) >>> 15;
      t = QB - t;
      t = (t * x2) >>> 15;
      t = QA - t;
      s = (x * t) >>> 16;
      return a[15] ? -s : s;
    endfunction

    function void note_pose(logic [3:0] idx, logic signed [19:0] x, logic signed [19:0] y,
                            logic [15:0] h, bit reseed);
      longint dx, dy, dth, rot, ofs, step, v, n, s, c;
      logic signed [15:0] dh;
      logic [15:0] phi;
      res_t r;
      if (!enable) return;
      if (!reseed && known[idx]) begin
        dx = longint'(x) - longint'(last_x[idx]);
        dy = longint'(y) - longint'(last_y[idx]);
        dh = h - last_h[idx];
        dth = longint'(dh);
        rot = longint'(radius) * dth * TURN_GAIN;
        ofs = longint'(bias) * (longint'(1) << FRAC_BITS);
        step = (qstep != 0 ? longint'(qstep) : longint'(1)) << FRAC_BITS;
        r.idx = idx;
        for (int k = 0; k < 4; k++) begin
          phi = mount[k] + h;
          s = sine_q15(phi);
          c = sine_q15(phi + QUARTER);
          v = (dx * s - dy * c) * MOVE_GAIN - rot + ofs;
          if (v >= 0) n = (v + step / 2) / step;
          else n = -((-v + step / 2) / step);
          if (qstep != 0) n = n * longint'(qstep);
          if (n > 32767) n = 32767;
          if (n < -32768) n = -32768;
          r.spd[k] = n[15:0];
        end
        speeds_due.push_back(r);
      end
      last_x[idx] = x;
      last_y[idx] = y;
      last_h[idx] = h;
      known[idx] = 1'b1;
    endfunction

    function void check_speeds(res_t got);
      res_t want;
      string nm[4] = '{"speed_front_left", "speed_back_left", "speed_back_right",
                       "speed_front_right"};
      if (speeds_due.size() == 0) begin
        $error("unexpected result word, out_index %0d", got.idx);
        failures++;
        return;
      end
      want = speeds_due.pop_front();
      if (got.idx !== want.idx) begin
        $error("out_index: expected %0d, actual %0d", want.idx, got.idx);
        failures++;
      end
      for (int k = 0; k < 4; k++)
        if (got.spd[k] !== want.spd[k]) begin
          $error("%s: expected %0d, actual %0d", nm[k], $signed(want.spd[k]),
                 $signed(got.spd[k]));
          failures++;
        end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [IDX_W-1:0] robot_index_i = '0;
  logic signed [POS_W-1:0] pos_x_i = '0, pos_y_i = '0;
  logic [HEAD_W-1:0] heading_i = '0;
  logic reseed_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [IDX_W-1:0] out_index_o;
  logic signed [SPD_W-1:0] speed_front_left_o, speed_back_left_o;
  logic signed [SPD_W-1:0] speed_back_right_o, speed_front_right_o;

  wheel_scoreboard sb = new();
  bit steady = 1'b0;
  int cycles = 0;
  int words_out = 0;
  int hold_left = 0;
  bit held = 1'b0;
  logic signed [POS_W-1:0] trk_x[16];
  logic signed [POS_W-1:0] trk_y[16];
  logic [HEAD_W-1:0] trk_h[16];

  omni_wheel_speed_from_pose uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // drain results; stall once for a long stretch so the pipe backs up
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_speeds({out_index_o, speed_front_right_o, speed_back_right_o,
                         speed_back_left_o, speed_front_left_o});
        words_out++;
      end
      if (!held && words_out == 400) begin
        held = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= 38);
      end
    end
  end

  task automatic write_reg(reg_idx_e r, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_reg(r, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_pose(logic [3:0] idx, logic signed [19:0] x, logic signed [19:0] y,
                           logic [15:0] h, bit rs);
    if (!steady)
      while ($urandom_range(99) < 38) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    in_valid_i <= 1'b1;
    robot_index_i <= idx;
    pos_x_i <= x;
    pos_y_i <= y;
    heading_i <= h;
    reseed_i <= rs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_pose(idx, x, y, h, rs);
    trk_x[idx] = x;
    trk_y[idx] = y;
    trk_h[idx] = h;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.speeds_due.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic random_poses(int count);
    logic [3:0] idx;
    int pick, t;
    logic signed [19:0] x, y;
    logic [15:0] h;
    for (int i = 0; i < count; i++) begin
      idx = 4'($urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_pose(idx, POS_W'($urandom), POS_W'($urandom), HEAD_W'($urandom),
                  1'($urandom_range(1)));
      end else begin
        t = int'(trk_x[idx]) + int'($urandom_range(8000)) - 4000;
        x = t[19:0];
        t = int'(trk_y[idx]) + int'($urandom_range(8000)) - 4000;
        y = t[19:0];
        h = trk_h[idx] + 16'($urandom_range(6000)) - 16'd3000;
        send_pose(idx, x, y, h, pick < 15);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) begin
      trk_x[i] = '0;
      trk_y[i] = '0;
      trk_h[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pose(0, 0, 0, 0, 0);
    send_pose(0, 0, 0, 0, 0);
    send_pose(0, 20'sh80000, 20'sh80000, 16'hffff, 1);
    send_pose(0, 20'sh7ffff, 20'sh7ffff, 16'h0001, 0);
    send_pose(0, 20'sh80000, 20'sh7ffff, 16'h8001, 0);
    send_pose(1, 100, -100, 16'h0000, 0);
    send_pose(1, 100, -100, 16'h8000, 0);
    send_pose(1, 500, 500, 16'h0000, 0);
    send_pose(1, -3000, 7000, 16'h4000, 1);
    send_pose(1, -2900, 7100, 16'h4100, 0);
    send_pose(15, 20'sh7ffff, 20'sh80000, 16'h7fff, 0);
    send_pose(15, 20'sh80000, 20'sh7ffff, 16'hffff, 0);
    settle();
    write_reg(REG_ENABLE, 0);
    send_pose(1, 0, 0, 0, 0);
    send_pose(2, 0, 0, 0, 0);
    send_pose(15, 1, 1, 1, 1);
    settle();
    write_reg(REG_ENABLE, 1);
    send_pose(2, 123, 456, 789, 0);
    send_pose(1, -2800, 7000, 16'h4200, 0);

    steady = 1'b1;
    random_poses(300);
    settle();
    steady = 1'b0;
    write_reg(REG_ANGLE_FL, 0);
    write_reg(REG_ANGLE_BL, 16'hffff);
    write_reg(REG_ANGLE_BR, 16'h8000);
    write_reg(REG_ANGLE_FR, 16'h4000);
    write_reg(REG_RADIUS, 255);
    write_reg(REG_BIAS, 1000);
    write_reg(REG_QSTEP, 1000);
    random_poses(350);
    settle();
    write_reg(REG_RADIUS, 0);
    write_reg(REG_BIAS, -1000);
    write_reg(REG_QSTEP, 1);
    random_poses(350);
    settle();
    write_reg(REG_ENABLE, 0);
    random_poses(40);
    settle();
    write_reg(REG_ENABLE, 1);
    for (int p = 0; p < 3; p++) begin
      write_reg(REG_ANGLE_FL, $urandom);
      write_reg(REG_ANGLE_BL, $urandom);
      write_reg(REG_ANGLE_BR, $urandom);
      write_reg(REG_ANGLE_FR, $urandom);
      write_reg(REG_RADIUS, $urandom_range(255));
      write_reg(REG_BIAS, 32'($urandom_range(2000)) - 32'd1000);
      write_reg(REG_QSTEP, $urandom_range(3) == 0 ? 0 : $urandom_range(1000));
      random_poses(270);
      settle();
    end

    if (sb.failures == 0 && sb.speeds_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
